[rtl/core/dis_pkg.sv]
package dis_pkg;

  localparam int DataRamDepthDef = 2048;
  localparam int StackDepthDef   = 16;

  localparam logic [15:0] SrKeepMask = 16'h907c;
  localparam logic [15:0] SrRqm      = 16'h8000;
  localparam logic [10:0] DpHiBank   = 11'h040;

  // instruction classes
  localparam logic [1:0] ClsOp = 2'd0;
  localparam logic [1:0] ClsRt = 2'd1;
  localparam logic [1:0] ClsJp = 2'd2;
  localparam logic [1:0] ClsLd = 2'd3;

  // move sources
  localparam logic [3:0] SrcTrb = 4'd0;
  localparam logic [3:0] SrcA   = 4'd1;
  localparam logic [3:0] SrcB   = 4'd2;
  localparam logic [3:0] SrcTr  = 4'd3;
  localparam logic [3:0] SrcDp  = 4'd4;
  localparam logic [3:0] SrcRp  = 4'd5;
  localparam logic [3:0] SrcRo  = 4'd6;
  localparam logic [3:0] SrcSgn = 4'd7;
  localparam logic [3:0] SrcDr  = 4'd8;
  localparam logic [3:0] SrcDrn = 4'd9;
  localparam logic [3:0] SrcSr  = 4'd10;
  localparam logic [3:0] SrcSim = 4'd11;
  localparam logic [3:0] SrcSil = 4'd12;
  localparam logic [3:0] SrcK   = 4'd13;
  localparam logic [3:0] SrcL   = 4'd14;

  // move destinations
  localparam logic [3:0] DstA   = 4'd1;
  localparam logic [3:0] DstB   = 4'd2;
  localparam logic [3:0] DstTr  = 4'd3;
  localparam logic [3:0] DstDp  = 4'd4;
  localparam logic [3:0] DstRp  = 4'd5;
  localparam logic [3:0] DstDr  = 4'd6;
  localparam logic [3:0] DstSr  = 4'd7;
  localparam logic [3:0] DstSol = 4'd8;
  localparam logic [3:0] DstSom = 4'd9;
  localparam logic [3:0] DstK   = 4'd10;
  localparam logic [3:0] DstKlr = 4'd11;
  localparam logic [3:0] DstKlm = 4'd12;
  localparam logic [3:0] DstL   = 4'd13;
  localparam logic [3:0] DstTrb = 4'd14;
  localparam logic [3:0] DstMem = 4'd15;

  // ALU functions
  localparam logic [3:0] AluNop = 4'd0;
  localparam logic [3:0] AluOr  = 4'd1;
  localparam logic [3:0] AluAnd = 4'd2;
  localparam logic [3:0] AluXor = 4'd3;
  localparam logic [3:0] AluSub = 4'd4;
  localparam logic [3:0] AluAdd = 4'd5;
  localparam logic [3:0] AluSbb = 4'd6;
  localparam logic [3:0] AluAdc = 4'd7;
  localparam logic [3:0] AluDec = 4'd8;
  localparam logic [3:0] AluInc = 4'd9;
  localparam logic [3:0] AluCmp = 4'd10;
  localparam logic [3:0] AluShr = 4'd11;
  localparam logic [3:0] AluShl = 4'd12;
  localparam logic [3:0] AluSl2 = 4'd13;
  localparam logic [3:0] AluSl4 = 4'd14;

  // jump codes
  localparam logic [8:0] JmpSo   = 9'h000;
  localparam logic [8:0] JmpCondLo = 9'h080;
  localparam logic [8:0] JmpCondHi = 9'h0af;
  localparam logic [8:0] JmpDpz  = 9'h0b0;
  localparam logic [8:0] JmpDpnz = 9'h0b1;
  localparam logic [8:0] JmpDpf  = 9'h0b2;
  localparam logic [8:0] JmpDpnf = 9'h0b3;
  localparam logic [8:0] JmpNrqm = 9'h0bc;
  localparam logic [8:0] JmpRqm  = 9'h0be;
  localparam logic [8:0] JmpLo   = 9'h100;
  localparam logic [8:0] JmpHi   = 9'h101;
  localparam logic [8:0] CallLo  = 9'h140;
  localparam logic [8:0] CallHi  = 9'h141;

  // flag bits
  localparam int FOv0 = 0;
  localparam int FOv1 = 1;
  localparam int FZ   = 2;
  localparam int FC   = 3;
  localparam int FS0  = 4;
  localparam int FS1  = 5;

  typedef struct packed {
    logic [23:0] instruction_word;
    logic [15:0] rom_data;
    logic [15:0] serial_in;
  } dis_in_t;

  typedef struct packed {
    logic [13:0] next_pc;
    logic [10:0] rom_address;
    logic [15:0] data_out;
    logic [15:0] status_out;
    logic [15:0] serial_out;
  } dis_out_t;

endpackage

[rtl/core/dsp_instruction_step_core.sv]
// One 24-bit instruction of a 16-bit fixed-point DSP executes per item, one item per
// clock: the whole step runs between the input handshake and the result register, and
// a new item is taken only when the result register is empty or its item leaves in the
// same cycle. After reset the block clears its data RAM, one word a cycle, through all
// DATA_RAM_DEPTH words, and holds in_stall high until that pass ends. The data RAM read
// words for the next item are fetched at the end of each step, so they are ready when
// the next item is taken. Each result carries the next fetch address, the data ROM
// address, and the DR, SR and SO registers.
module dsp_instruction_step_core
  import dis_pkg::*;
#(
  parameter int DATA_RAM_DEPTH = DataRamDepthDef,
  parameter int STACK_DEPTH    = StackDepthDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dis_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output dis_out_t out_data
);

  localparam int AW  = $clog2(DATA_RAM_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH);
  localparam logic [AW-1:0]  RamLast  = AW'(DATA_RAM_DEPTH - 1);
  localparam logic [SPW-1:0] StkLast  = SPW'(STACK_DEPTH - 1);
  localparam logic [13:0]    RamDepth = 14'(DATA_RAM_DEPTH);

  // address is below eight times the depth, so three compare-subtract steps reduce it
  function automatic logic [AW-1:0] ram_idx(input logic [10:0] a);
    logic [13:0] v;
    v = {3'b0, a};
    for (int s = 2; s >= 0; s--) begin
      if (v >= (RamDepth << s)) v = v - (RamDepth << s);
    end
    return v[AW-1:0];
  endfunction

  logic [13:0] pc_r, pc_nxt;
  logic [15:0] acc_a_r, acc_a_nxt, acc_b_r, acc_b_nxt;
  logic [5:0]  fl_a_r, fl_a_nxt, fl_b_r, fl_b_nxt;
  logic [15:0] tr_r, tr_nxt, trb_r, trb_nxt;
  logic [10:0] dp_r, dp_nxt, rp_r, rp_nxt;
  logic [15:0] dr_r, dr_nxt, sr_r, sr_nxt, so_r, so_nxt;
  logic [15:0] k_r, k_nxt, l_r, l_nxt;
  logic [15:0] m_r, m_nxt, n_r, n_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [13:0] stk_r [STACK_DEPTH];
  logic        push;

  logic        clr_busy_r;
  logic [AW-1:0] clr_addr_r;
  logic        out_valid_r;
  dis_out_t    out_r;

  logic [15:0] mem [DATA_RAM_DEPTH];
  logic [15:0] rd0_r, rd1_r;
  logic        ram_we, mem_wr;
  logic [AW-1:0] ram_wa, ra0, ra1;
  logic [15:0] ram_wd, mem_wd;

  logic        accept;
  logic signed [31:0] prod;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = clr_busy_r || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic [23:0] w;
    logic [15:0] bus, id, p, q, r;
    logic [5:0]  f;
    logic        c, ov, cy, ov1, useb, take, bit_v;
    logic [3:0]  fn, dst;
    logic [13:0] jp;
    logic [8:0]  brch, kk;
    logic [5:0]  fsel;
    logic        do_store, do_pop;

    w = in_data.instruction_word;
    pc_nxt = pc_r; acc_a_nxt = acc_a_r; acc_b_nxt = acc_b_r;
    fl_a_nxt = fl_a_r; fl_b_nxt = fl_b_r; tr_nxt = tr_r; trb_nxt = trb_r;
    dp_nxt = dp_r; rp_nxt = rp_r; dr_nxt = dr_r; sr_nxt = sr_r; so_nxt = so_r;
    k_nxt = k_r; l_nxt = l_r; sp_nxt = sp_r; push = 1'b0;
    ram_we = 1'b0; ram_wd = 16'h0;
    bus = 16'h0; id = 16'h0; p = 16'h0; q = 16'h0; r = 16'h0; f = 6'h0;
    c = 1'b0; ov = 1'b0; cy = 1'b0; ov1 = 1'b0; take = 1'b0; bit_v = 1'b0;
    fn = w[19:16]; dst = w[3:0]; useb = w[15];
    brch = w[21:13]; kk = brch - JmpCondLo; fsel = 6'h0;
    do_store = 1'b0; do_pop = 1'b0;
    jp = 14'h0;

    if (accept) begin
      pc_nxt = pc_r + 14'd1;
      if (w[23:22] == ClsOp || w[23:22] == ClsRt) begin
        case (w[7:4])
          SrcTrb: bus = trb_r;
          SrcA:   bus = acc_a_r;
          SrcB:   bus = acc_b_r;
          SrcTr:  bus = tr_r;
          SrcDp:  bus = {5'h0, dp_r};
          SrcRp:  bus = {5'h0, rp_r};
          SrcRo:  bus = in_data.rom_data;
          SrcSgn: bus = fl_a_r[FS1] ? 16'h7fff : 16'h8000;
          SrcDr:  begin bus = dr_r; sr_nxt = sr_r | SrRqm; end
          SrcDrn: bus = dr_r;
          SrcSr:  bus = sr_r;
          SrcSim, SrcSil: bus = in_data.serial_in;
          SrcK:   bus = k_r;
          SrcL:   bus = l_r;
          default: bus = rd0_r;
        endcase

        if (fn != AluNop) begin
          case (w[21:20])
            2'd0:    p = rd0_r;
            2'd1:    p = bus;
            2'd2:    p = m_r;
            default: p = n_r;
          endcase
          q = useb ? acc_b_r : acc_a_r;
          f = useb ? fl_b_r : fl_a_r;
          c = useb ? fl_a_r[FC] : fl_b_r[FC];
          case (fn)
            AluOr:  r = q | p;
            AluAnd: r = q & p;
            AluXor: r = q ^ p;
            AluSub: r = q - p;
            AluAdd: r = q + p;
            AluSbb: r = q - p - {15'h0, c};
            AluAdc: r = q + p + {15'h0, c};
            AluDec: begin r = q - 16'd1; p = 16'd1; end
            AluInc: begin r = q + 16'd1; p = 16'd1; end
            AluCmp: r = ~q;
            AluShr: r = {q[15], q[15:1]};
            AluShl: r = {q[14:0], c};
            AluSl2: r = {q[13:0], 2'b11};
            AluSl4: r = {q[11:0], 4'hf};
            default: r = {q[7:0], q[15:8]};
          endcase
          f[FS0] = r[15];
          f[FZ]  = (r == 16'h0);
          if (fn >= AluSub && fn <= AluInc) begin
            if (fn[0]) begin
              ov = (q[15] ^ r[15]) & ~(q[15] ^ p[15]);
              cy = r < q;
            end else begin
              ov = (q[15] ^ r[15]) & (q[15] ^ p[15]);
              cy = r > q;
            end
            f[FC]  = cy;
            f[FOv0] = ov;
            if (ov) begin
              ov1 = f[FOv1];
              f[FS1]  = ov1 ^ ~r[15];
              f[FOv1] = ~ov1;
            end
          end else begin
            f[FOv0] = 1'b0;
            f[FOv1] = 1'b0;
            f[FC]   = (fn == AluShr && q[0]) || (fn == AluShl && q[15]);
          end
          if (useb) begin acc_b_nxt = r; fl_b_nxt = f; end
          else begin acc_a_nxt = r; fl_a_nxt = f; end
        end
        id = bus;
        do_store = 1'b1;
        do_pop = (w[23:22] == ClsRt);
      end else if (w[23:22] == ClsLd) begin
        id = w[21:6];
        do_store = 1'b1;
      end else begin
        jp = {pc_nxt[13], w[1:0], w[12:2]};
        if (brch >= JmpCondLo && brch <= JmpCondHi && !brch[0]) begin
          fsel = kk[2] ? fl_b_r : fl_a_r;
          case (kk[5:3])
            3'd0:    bit_v = fsel[FC];
            3'd1:    bit_v = fsel[FZ];
            3'd2:    bit_v = fsel[FOv0];
            3'd3:    bit_v = fsel[FOv1];
            3'd4:    bit_v = fsel[FS0];
            default: bit_v = fsel[FS1];
          endcase
          take = kk[1] ? bit_v : !bit_v;
        end else begin
          case (brch)
            JmpSo:   pc_nxt = so_r[13:0];
            JmpDpz:  take = dp_r[3:0] == 4'h0;
            JmpDpnz: take = dp_r[3:0] != 4'h0;
            JmpDpf:  take = dp_r[3:0] == 4'hf;
            JmpDpnf: take = dp_r[3:0] != 4'hf;
            JmpNrqm: take = !sr_r[15];
            JmpRqm:  take = sr_r[15];
            JmpLo:   pc_nxt = {1'b0, jp[12:0]};
            JmpHi:   pc_nxt = {1'b1, jp[12:0]};
            CallLo:  begin push = 1'b1; pc_nxt = {1'b0, jp[12:0]}; end
            CallHi:  begin push = 1'b1; pc_nxt = {1'b1, jp[12:0]}; end
            default: take = 1'b0;
          endcase
        end
        if (take) pc_nxt = jp;
        if (push) sp_nxt = (sp_r == StkLast) ? '0 : sp_r + SPW'(1);
      end

      if (do_store) begin
        case (dst)
          DstA:   acc_a_nxt = id;
          DstB:   acc_b_nxt = id;
          DstTr:  tr_nxt = id;
          DstDp:  dp_nxt = id[10:0];
          DstRp:  rp_nxt = id[10:0];
          DstDr:  begin dr_nxt = id; sr_nxt = sr_nxt | SrRqm; end
          DstSr:  sr_nxt = (sr_nxt & SrKeepMask) | (id & ~SrKeepMask);
          DstSol, DstSom: so_nxt = id;
          DstK:   k_nxt = id;
          DstKlr: begin k_nxt = id; l_nxt = in_data.rom_data; end
          DstKlm: begin l_nxt = id; k_nxt = rd1_r; end
          DstL:   l_nxt = id;
          DstTrb: trb_nxt = id;
          DstMem: begin ram_we = 1'b1; ram_wd = id; end
          default: ram_we = 1'b0;
        endcase
      end

      if (w[23:22] == ClsOp || w[23:22] == ClsRt) begin
        case (w[14:13])
          2'd1:    dp_nxt = {dp_nxt[10:4], dp_nxt[3:0] + 4'd1};
          2'd2:    dp_nxt = {dp_nxt[10:4], dp_nxt[3:0] - 4'd1};
          2'd3:    dp_nxt = {dp_nxt[10:4], 4'h0};
          default: dp_nxt = dp_nxt;
        endcase
        dp_nxt = dp_nxt ^ {3'h0, w[12:9], 4'h0};
        if (w[8]) rp_nxt = rp_nxt - 11'd1;
      end

      if (do_pop) begin
        sp_nxt = (sp_r == '0) ? StkLast : sp_r - SPW'(1);
        pc_nxt = stk_r[sp_nxt];
      end
    end
  end

  // product of the operands this item leaves behind
  assign prod  = 32'($signed(k_nxt)) * 32'($signed(l_nxt));
  assign m_nxt = prod[30:15];
  assign n_nxt = {prod[14:0], 1'b0};

  assign ram_wa = ram_idx(dp_r);
  assign ra0    = ram_idx(dp_nxt);
  assign ra1    = ram_idx(dp_nxt | DpHiBank);
  assign mem_wr = clr_busy_r || ram_we;
  always_comb begin
    mem_wd = clr_busy_r ? 16'h0 : ram_wd;
  end

  logic [AW-1:0] mem_wa;
  assign mem_wa = clr_busy_r ? clr_addr_r : ram_wa;

  always_ff @(posedge clk) begin
    if (mem_wr) mem[mem_wa] <= mem_wd;
    rd0_r <= (mem_wr && mem_wa == ra0) ? mem_wd : mem[ra0];
    rd1_r <= (mem_wr && mem_wa == ra1) ? mem_wd : mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == RamLast) clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0; acc_a_r <= '0; acc_b_r <= '0; fl_a_r <= '0; fl_b_r <= '0;
      tr_r <= '0; trb_r <= '0; dp_r <= '0; rp_r <= 11'h7ff;
      dr_r <= '0; sr_r <= '0; so_r <= '0; k_r <= '0; l_r <= '0;
      m_r <= '0; n_r <= '0; sp_r <= '0;
      for (int i = 0; i < STACK_DEPTH; i++) stk_r[i] <= '0;
    end else if (accept) begin
      pc_r <= pc_nxt; acc_a_r <= acc_a_nxt; acc_b_r <= acc_b_nxt;
      fl_a_r <= fl_a_nxt; fl_b_r <= fl_b_nxt; tr_r <= tr_nxt; trb_r <= trb_nxt;
      dp_r <= dp_nxt; rp_r <= rp_nxt; dr_r <= dr_nxt; sr_r <= sr_nxt; so_r <= so_nxt;
      k_r <= k_nxt; l_r <= l_nxt; m_r <= m_nxt; n_r <= n_nxt; sp_r <= sp_nxt;
      if (push) stk_r[sp_r] <= pc_r + 14'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r.next_pc     <= pc_nxt;
      out_r.rom_address <= rp_nxt;
      out_r.data_out    <= dr_nxt;
      out_r.status_out  <= sr_nxt;
      out_r.serial_out  <= so_nxt;
    end
  end

endmodule
